// ===== hw/rtl/versatile_interface_adapter_defines.svh =====
// Assertion macros for the versatile interface adapter
`ifndef VERSATILE_INTERFACE_ADAPTER_DEFINES_SVH
`define VERSATILE_INTERFACE_ADAPTER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define VIA_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define VIA_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define VIA_ASSERT(label, clk, rst_n, prop)
`define VIA_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// ===== hw/rtl/via_pkg.sv =====
// Shared constants and types for the versatile interface adapter
`timescale 1ns / 1ps
`default_nettype none
package via_pkg;
    localparam logic [15:0] T1_LATCH_RESET = 16'hb5f3;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;
    localparam logic [3:0] REG_ORB  = 4'd0;
    localparam logic [3:0] REG_ORA  = 4'd1;
    localparam logic [3:0] REG_DDRB = 4'd2;
    localparam logic [3:0] REG_DDRA = 4'd3;
    localparam logic [3:0] REG_T1CL = 4'd4;
    localparam logic [3:0] REG_T1CH = 4'd5;
    localparam logic [3:0] REG_T1LL = 4'd6;
    localparam logic [3:0] REG_T1LH = 4'd7;
    localparam logic [3:0] REG_T2CL = 4'd8;
    localparam logic [3:0] REG_T2CH = 4'd9;
    localparam logic [3:0] REG_SR   = 4'd10;
    localparam logic [3:0] REG_PCR  = 4'd11;
    localparam logic [3:0] REG_ACR  = 4'd12;
    localparam logic [3:0] REG_IER  = 4'd13;
    localparam logic [3:0] REG_IFR  = 4'd14;
    localparam logic [3:0] REG_ORA_NH = 4'd15;
    localparam logic [6:0] F_CA2 = 7'h01;
    localparam logic [6:0] F_CA1 = 7'h02;
    localparam logic [6:0] F_CB2 = 7'h08;
    localparam logic [6:0] F_CB1 = 7'h10;
    localparam logic [6:0] F_T2  = 7'h20;
    localparam logic [6:0] F_T1  = 7'h40;
    localparam logic [2:0] SR_OUT_PHI2 = 3'b110;
    localparam logic [16:0] EXTRA_CYCLES = 17'd3;

    // Timer events handed to the register core
    typedef struct packed {
        logic t1_expire;
        logic t1_reload;
        logic t2_expire;
    } t_tmr_evt;
endpackage
`default_nettype wire

// ===== hw/rtl/via_timer.sv =====
// Down counter with one-shot or reload behavior, one count per cycle while i_adv is high
`timescale 1ns / 1ps
`default_nettype none
module via_timer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_adv,
    input  wire logic        i_continuous,
    input  wire logic [15:0] i_latch,
    input  wire logic        i_load,
    input  wire logic        i_stop_load,
    output logic             o_expire,
    output logic             o_running,
    output logic [16:0]      o_remaining
);
    logic [16:0] r_rem, n_rem;
    logic        r_run, n_run;
    logic [16:0] w_dec;

    always_comb begin
        w_dec    = (r_rem != 17'd0) ? r_rem - 17'd1 : r_rem;
        o_expire = i_adv && r_run && (w_dec == 17'd0);
        n_rem    = r_rem;
        n_run    = r_run;
        if (i_adv && r_run) begin
            n_rem = w_dec;
            if (w_dec == 17'd0) begin
                if (i_continuous) begin
                    n_rem = {1'b0, i_latch} + via_pkg::EXTRA_CYCLES;
                end else begin
                    n_run = 1'b0;
                end
            end
        end
        if (i_load) begin
            n_rem = {1'b0, i_latch} + via_pkg::EXTRA_CYCLES;
            n_run = 1'b1;
        end else if (i_stop_load) begin
            n_rem = {1'b0, i_latch} + via_pkg::EXTRA_CYCLES;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= '0;
            r_run <= 1'b0;
        end else begin
            r_rem <= n_rem;
            r_run <= n_run;
        end
    end

    assign o_running   = r_run;
    assign o_remaining = r_rem;
endmodule
`default_nettype wire

// ===== hw/rtl/versatile_interface_adapter.sv =====
// Top level: 6522-style interface adapter with ports, control lines and timers
//
// channel  | valid          | stall           | payload
// input    | i_in_valid     | o_in_stall      | bus command, offset, data, pins
// output   | o_out_valid    | i_out_stall     | read data, port drives, irq, shift byte
// config   | i_cfg_we       | (none)          | i_cfg_data: timer 1 latch
//
// One transaction a cycle while the output is not stalled; the result appears the cycle after acceptance.
// All work is one pass of logic between the input and the output register.
// Timers advance only on accepted transactions; stalls freeze all state except
// the timer 1 latch, still written by i_cfg_we. Reset is synchronous and active low.
`timescale 1ns / 1ps
`default_nettype none
`include "versatile_interface_adapter_defines.svh"
module versatile_interface_adapter #(
    parameter logic [15:0] T1_LATCH_RESET = via_pkg::T1_LATCH_RESET
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [1:0] i_command,
    input  wire logic [3:0] i_reg_offset,
    input  wire logic [7:0] i_write_data,
    input  wire logic [7:0] i_port_a_pins,
    input  wire logic [7:0] i_port_b_pins,
    input  wire logic       i_ca1_pin,
    input  wire logic       i_ca2_pin,
    input  wire logic       i_cb1_pin,
    input  wire logic       i_cb2_pin,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [7:0]      o_read_data,
    output logic [7:0]      o_port_a_drive,
    output logic [7:0]      o_port_a_dir,
    output logic [7:0]      o_port_b_drive,
    output logic [7:0]      o_port_b_dir,
    output logic            o_ca2_out,
    output logic            o_cb2_out,
    output logic            o_irq,
    output logic            o_shift_out_valid,
    output logic [7:0]      o_shift_out_data
);
    logic w_acc;
    logic [7:0] r_in_a, r_in_b, r_out_a, r_out_b, r_dir_a, r_dir_b;
    logic [7:0] n_in_a, n_in_b, n_out_a, n_out_b, n_dir_a, n_dir_b;
    logic [3:0] r_prev, n_prev;
    logic r_ca2, r_cb2, n_ca2, n_cb2;
    logic [15:0] r_t1_latch, n_t1_latch, r_t1_snap, n_t1_snap;
    logic [15:0] r_t2_latch, n_t2_latch, r_t2_snap, n_t2_snap;
    logic [7:0] r_sr, n_sr, r_pcr, n_pcr, r_acr, n_acr;
    logic [6:0] r_ier, n_ier, r_ifr, n_ifr;
    logic [7:0] n_rd;
    logic n_sv;
    logic r_ovalid;
    logic [7:0] r_o_rd, r_o_sd;
    logic r_o_sv;

    via_pkg::t_tmr_evt w_evt;
    logic w_t1_run, w_t2_run, w_t1_load, w_t2_load, w_t2_stop_load;
    logic [16:0] w_t1_rem, w_t2_rem;
    logic w_wr, w_rd;
    logic [15:0] w_t1_cnt, w_t2_cnt;

    assign o_in_stall = r_ovalid && i_out_stall;
    assign w_acc = i_in_valid && !o_in_stall;
    assign w_wr = i_command == via_pkg::CMD_WRITE;
    assign w_rd = i_command == via_pkg::CMD_READ;

    // timer 1 latch can change in this cycle by a latch or config write; load uses it
    assign w_t1_load = w_acc && w_wr &&
        (i_reg_offset == via_pkg::REG_T1CH ||
         (i_reg_offset == via_pkg::REG_ACR && i_write_data[6]));
    assign w_t2_load = w_acc && w_wr && i_reg_offset == via_pkg::REG_T2CH && !r_acr[5];
    assign w_t2_stop_load = 1'b0;

    // free-running reload counts from the latch as it stood before this bus write
    via_timer u_t1 (
        .i_clk, .i_rst_n, .i_adv(w_acc), .i_continuous(r_acr[6]),
        .i_latch(w_t1_load ? n_t1_latch : r_t1_latch), .i_load(w_t1_load),
        .i_stop_load(1'b0),
        .o_expire(w_evt.t1_expire), .o_running(w_t1_run), .o_remaining(w_t1_rem)
    );
    via_timer u_t2 (
        .i_clk, .i_rst_n, .i_adv(w_acc), .i_continuous(1'b0),
        .i_latch(n_t2_latch), .i_load(w_t2_load), .i_stop_load(w_t2_stop_load),
        .o_expire(w_evt.t2_expire), .o_running(w_t2_run), .o_remaining(w_t2_rem)
    );
    assign w_evt.t1_reload = w_evt.t1_expire && r_acr[6];

    always_comb begin
        logic t1_run_now, t2_run_now;
        logic [16:0] t1_rem_now, t2_rem_now;
        n_in_a = r_in_a; n_in_b = r_in_b; n_out_a = r_out_a; n_out_b = r_out_b;
        n_dir_a = r_dir_a; n_dir_b = r_dir_b; n_prev = r_prev;
        n_ca2 = r_ca2; n_cb2 = r_cb2; n_t1_latch = r_t1_latch; n_t1_snap = r_t1_snap;
        n_t2_latch = r_t2_latch; n_t2_snap = r_t2_snap; n_sr = r_sr; n_pcr = r_pcr;
        n_acr = r_acr; n_ier = r_ier; n_ifr = r_ifr; n_rd = 8'h00; n_sv = 1'b0;
        // counter state after this cycle's count
        t1_run_now = w_t1_run && !(w_evt.t1_expire && !r_acr[6]);
        t2_run_now = w_t2_run && !w_evt.t2_expire;
        t1_rem_now = w_evt.t1_reload ? {1'b0, r_t1_latch} + via_pkg::EXTRA_CYCLES
                   : (w_t1_run && w_t1_rem != 17'd0) ? w_t1_rem - 17'd1 : w_t1_rem;
        t2_rem_now = (w_t2_run && w_t2_rem != 17'd0) ? w_t2_rem - 17'd1 : w_t2_rem;
        w_t1_cnt = t1_run_now ? t1_rem_now[15:0] : r_t1_snap;
        w_t2_cnt = t2_run_now ? t2_rem_now[15:0] : r_t2_snap;
        // timer events
        if (w_evt.t1_expire) begin
            if (r_acr[7]) begin
                n_out_b[7] = r_acr[6] ? ~r_out_b[7] : 1'b1;
            end
            n_ifr = n_ifr | via_pkg::F_T1;
        end
        if (w_evt.t2_expire) begin
            n_ifr = n_ifr | via_pkg::F_T2;
        end
        // control line edges
        if (i_ca1_pin != r_prev[0]) begin
            if (i_ca1_pin == r_pcr[0]) begin
                if (r_acr[0]) n_in_a = i_port_a_pins;
                n_ifr = n_ifr | via_pkg::F_CA1;
                if (r_pcr[3:2] == 2'b10) n_ca2 = 1'b1;
            end
            n_prev[0] = i_ca1_pin;
        end
        if (!r_pcr[3] && i_ca2_pin != r_prev[1]) begin
            if ((i_ca2_pin && r_pcr[3:2] == 2'b01) || (!i_ca2_pin && r_pcr[3:2] == 2'b00))
                n_ifr = n_ifr | via_pkg::F_CA2;
            n_prev[1] = i_ca2_pin;
        end
        if (i_cb1_pin != r_prev[2]) begin
            if (i_cb1_pin == r_pcr[4]) begin
                if (r_acr[1]) n_in_b = i_port_b_pins;
                n_ifr = n_ifr | via_pkg::F_CB1;
                if (r_pcr[7:6] == 2'b10) n_cb2 = 1'b1;
            end
            n_prev[2] = i_cb1_pin;
        end
        if (!r_pcr[7] && i_cb2_pin != r_prev[3]) begin
            if ((i_cb2_pin && r_pcr[7:6] == 2'b01) || (!i_cb2_pin && r_pcr[7:6] == 2'b00))
                n_ifr = n_ifr | via_pkg::F_CB2;
            n_prev[3] = i_cb2_pin;
        end
        // bus access
        if (w_rd) begin
            case (i_reg_offset)
                via_pkg::REG_ORB: begin
                    if (!r_acr[1]) n_in_b = i_port_b_pins;
                    n_ifr = n_ifr & ~(via_pkg::F_CB1 |
                        ((r_pcr[7] == 1'b0 && r_pcr[5]) ? 7'h00 : via_pkg::F_CB2));
                    n_rd = (n_out_b & r_dir_b) | (n_in_b & ~r_dir_b);
                end
                via_pkg::REG_ORA, via_pkg::REG_ORA_NH: begin
                    if (i_reg_offset == via_pkg::REG_ORA) begin
                        if (r_pcr[3:2] == 2'b10) n_ca2 = 1'b0;
                        n_ifr = n_ifr & ~(via_pkg::F_CA1 |
                            ((r_pcr[3] == 1'b0 && r_pcr[1]) ? 7'h00 : via_pkg::F_CA2));
                    end
                    if (!r_acr[0]) n_in_a = i_port_a_pins;
                    n_rd = (r_out_a & r_dir_a) | (n_in_a & ~r_dir_a);
                end
                via_pkg::REG_DDRB: n_rd = r_dir_b;
                via_pkg::REG_DDRA: n_rd = r_dir_a;
                via_pkg::REG_T1CL: begin
                    n_ifr = n_ifr & ~via_pkg::F_T1;
                    n_rd = w_t1_cnt[7:0];
                end
                via_pkg::REG_T1CH: n_rd = w_t1_cnt[15:8];
                via_pkg::REG_T1LL: n_rd = r_t1_latch[7:0];
                via_pkg::REG_T1LH: n_rd = r_t1_latch[15:8];
                via_pkg::REG_T2CL: begin
                    n_ifr = n_ifr & ~via_pkg::F_T2;
                    n_rd = w_t2_cnt[7:0];
                end
                via_pkg::REG_T2CH: n_rd = w_t2_cnt[15:8];
                via_pkg::REG_SR:   n_rd = r_sr;
                via_pkg::REG_PCR:  n_rd = r_pcr;
                via_pkg::REG_ACR:  n_rd = r_acr;
                via_pkg::REG_IER:  n_rd = {1'b1, r_ier};
                default:           n_rd = {|(n_ifr & r_ier), n_ifr};
            endcase
        end else if (w_wr) begin
            case (i_reg_offset)
                via_pkg::REG_ORB: begin
                    n_out_b = r_acr[7] ? {n_out_b[7], i_write_data[6:0]} : i_write_data;
                    n_ifr = n_ifr & ~(via_pkg::F_CB1 |
                        ((r_pcr[7] == 1'b0 && r_pcr[5]) ? 7'h00 : via_pkg::F_CB2));
                    if (r_pcr[7:6] == 2'b10) n_cb2 = 1'b0;
                end
                via_pkg::REG_ORA: begin
                    if (r_pcr[3:2] == 2'b10) n_ca2 = 1'b0;
                    n_ifr = n_ifr & ~(via_pkg::F_CA1 |
                        ((r_pcr[3] == 1'b0 && r_pcr[1]) ? 7'h00 : via_pkg::F_CA2));
                    n_out_a = i_write_data;
                end
                via_pkg::REG_ORA_NH: n_out_a = i_write_data;
                via_pkg::REG_DDRB: n_dir_b = i_write_data;
                via_pkg::REG_DDRA: n_dir_a = i_write_data;
                via_pkg::REG_T1CL, via_pkg::REG_T1LL:
                    n_t1_latch = {r_t1_latch[15:8], i_write_data};
                via_pkg::REG_T1LH: n_t1_latch = {i_write_data, r_t1_latch[7:0]};
                via_pkg::REG_T1CH: begin
                    n_t1_latch = {i_write_data, r_t1_latch[7:0]};
                    n_t1_snap = n_t1_latch;
                    n_ifr = n_ifr & ~via_pkg::F_T1;
                    if (r_acr[7]) n_out_b[7] = 1'b0;
                end
                via_pkg::REG_T2CL: n_t2_latch = {r_t2_latch[15:8], i_write_data};
                via_pkg::REG_T2CH: begin
                    n_t2_latch = {i_write_data, r_t2_latch[7:0]};
                    n_t2_snap = n_t2_latch;
                    n_ifr = n_ifr & ~via_pkg::F_T2;
                end
                via_pkg::REG_SR: begin
                    n_sr = i_write_data;
                    n_sv = r_acr[4:2] == via_pkg::SR_OUT_PHI2;
                end
                via_pkg::REG_PCR: begin
                    n_pcr = i_write_data;
                    if (i_write_data[3:2] == 2'b11) n_ca2 = i_write_data[1];
                    if (i_write_data[7:6] == 2'b11) n_cb2 = i_write_data[5];
                end
                via_pkg::REG_ACR: begin
                    n_acr = i_write_data;
                    // PB7 follows the timer state before any restart
                    if (i_write_data[7]) n_out_b[7] = ~t1_run_now;
                end
                via_pkg::REG_IER: begin
                    if (i_write_data[7]) n_ier = r_ier | i_write_data[6:0];
                    else n_ier = r_ier & ~i_write_data[6:0];
                end
                default: n_ifr = n_ifr & ~i_write_data[6:0];
            endcase
        end
        if (i_cfg_we) n_t1_latch = i_cfg_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_a <= '0; r_in_b <= '0; r_out_a <= '0; r_out_b <= '0;
            r_dir_a <= '0; r_dir_b <= '0; r_prev <= '0; r_ca2 <= 1'b0; r_cb2 <= 1'b0;
            r_t1_latch <= T1_LATCH_RESET; r_t1_snap <= '0;
            r_t2_latch <= '0; r_t2_snap <= '0; r_sr <= '0; r_pcr <= '0;
            r_acr <= '0; r_ier <= '0; r_ifr <= '0;
            r_ovalid <= 1'b0; r_o_rd <= '0; r_o_sv <= 1'b0; r_o_sd <= '0;
        end else begin
            if (w_acc) begin
                r_in_a <= n_in_a; r_in_b <= n_in_b; r_out_a <= n_out_a;
                r_out_b <= n_out_b; r_dir_a <= n_dir_a; r_dir_b <= n_dir_b;
                r_prev <= n_prev; r_ca2 <= n_ca2; r_cb2 <= n_cb2;
                r_t1_snap <= n_t1_snap; r_t2_latch <= n_t2_latch;
                r_t2_snap <= n_t2_snap; r_sr <= n_sr; r_pcr <= n_pcr;
                r_acr <= n_acr; r_ier <= n_ier; r_ifr <= n_ifr;
                r_o_rd <= n_rd; r_o_sv <= n_sv; r_o_sd <= n_sv ? i_write_data : 8'h00;
            end
            if (w_acc || i_cfg_we) r_t1_latch <= n_t1_latch;
            if (w_acc) r_ovalid <= 1'b1;
            else if (!i_out_stall) r_ovalid <= 1'b0;
        end
    end

    assign o_out_valid       = r_ovalid;
    assign o_read_data       = r_o_rd;
    assign o_port_a_drive    = r_out_a & r_dir_a;
    assign o_port_a_dir      = r_dir_a;
    assign o_port_b_drive    = r_out_b & r_dir_b;
    assign o_port_b_dir      = r_dir_b;
    assign o_ca2_out         = r_ca2;
    assign o_cb2_out         = r_cb2;
    assign o_irq             = |(r_ifr & r_ier);
    assign o_shift_out_valid = r_o_sv;
    assign o_shift_out_data  = r_o_sd;

    `VIA_ASSERT(a_stall_only_when_full, i_clk, i_rst_n, o_in_stall |-> o_out_valid)
    `VIA_ASSERT(a_sr_data_zero, i_clk, i_rst_n, !o_shift_out_valid |-> o_shift_out_data == 8'h00)
    `VIA_ASSERT(a_accept_gives_result, i_clk, i_rst_n, w_acc |=> o_out_valid)
    `VIA_ASSERT(a_state_holds_idle, i_clk, i_rst_n, !w_acc |=> $stable(r_ifr))
endmodule
`default_nettype wire

// ===== verif/versatile_interface_adapter_tb.sv =====
// Self-checking testbench for the versatile interface adapter: directed table, then random cycles
`timescale 1ns / 1ps
module versatile_interface_adapter_tb;
    localparam logic [1:0] CMD_IDLE = 2'd0;
    localparam logic [1:0] CMD_ALT  = 2'd3;
    localparam int         STALL_LIMIT = 2000;

    typedef struct {
        logic [1:0] cmd;
        logic [3:0] offs;
        logic [7:0] wdata;
        logic [7:0] pa;
        logic [7:0] pb;
        logic       ca1, ca2, cb1, cb2;
    } t_bus_cycle;

    typedef struct {
        logic [7:0] rd;
        logic [7:0] pa_drv, pa_dir, pb_drv, pb_dir;
        logic       ca2o, cb2o, irq, sov;
        logic [7:0] sod;
    } t_pin_state;

    typedef struct {
        t_bus_cycle cyc;
        bit         has_rd;
        logic [7:0] rd;
    } t_table_row;

    logic i_clk, i_rst_n, i_cfg_we, i_in_valid, i_out_stall;
    logic [15:0] i_cfg_data;
    logic [1:0] i_command;
    logic [3:0] i_reg_offset;
    logic [7:0] i_write_data, i_port_a_pins, i_port_b_pins;
    logic i_ca1_pin, i_ca2_pin, i_cb1_pin, i_cb2_pin;
    logic o_in_stall, o_out_valid, o_ca2_out, o_cb2_out, o_irq, o_shift_out_valid;
    logic [7:0] o_read_data, o_port_a_drive, o_port_a_dir, o_port_b_drive, o_port_b_dir;
    logic [7:0] o_shift_out_data;

    versatile_interface_adapter i_dut (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_data, .i_in_valid, .o_in_stall,
        .i_command, .i_reg_offset, .i_write_data, .i_port_a_pins, .i_port_b_pins,
        .i_ca1_pin, .i_ca2_pin, .i_cb1_pin, .i_cb2_pin, .o_out_valid, .i_out_stall,
        .o_read_data, .o_port_a_drive, .o_port_a_dir, .o_port_b_drive, .o_port_b_dir,
        .o_ca2_out, .o_cb2_out, .o_irq, .o_shift_out_valid, .o_shift_out_data
    );

    // Adapter state as the predictor sees it
    logic [7:0]  m_lat_a, m_lat_b, m_ora, m_orb, m_ddra, m_ddrb;
    logic [3:0]  m_prev;
    logic        m_ca2, m_cb2;
    logic [15:0] m_t1_latch, m_t1_snap, m_t2_latch, m_t2_snap;
    logic [16:0] m_t1_cnt, m_t2_cnt;
    logic        m_t1_run, m_t2_run;
    logic [7:0]  m_sr, m_pcr, m_acr, m_ifr;
    logic [6:0]  m_ier;

    t_pin_state  pending_q[$];
    t_table_row  rows[$];
    int          err_cnt;
    int          send_idle_pct, recv_stall_pct;
    int          quiet_cycles;
    logic        c_ca1, c_ca2, c_cb1, c_cb2;

    function automatic void irq_update();
        m_ifr[7] = |(m_ifr[6:0] & m_ier);
    endfunction

    function automatic void flag_set(logic [6:0] b);
        m_ifr[6:0] = m_ifr[6:0] | b;
        irq_update();
    endfunction

    function automatic void flag_clr(logic [6:0] b);
        m_ifr[6:0] = m_ifr[6:0] & ~b;
        irq_update();
    endfunction

    function automatic void port_a_ack();
        flag_clr(via_pkg::F_CA1 | (((m_pcr & 8'h0a) == 8'h02) ? 7'h00 : via_pkg::F_CA2));
    endfunction

    function automatic void port_b_ack();
        flag_clr(via_pkg::F_CB1 | (((m_pcr & 8'ha0) == 8'h20) ? 7'h00 : via_pkg::F_CB2));
    endfunction

    function automatic void t1_reload();
        m_t1_cnt = {1'b0, m_t1_latch} + via_pkg::EXTRA_CYCLES;
        m_t1_run = 1'b1;
    endfunction

    function automatic void model_reset(logic [15:0] latch);
        {m_lat_a, m_lat_b, m_ora, m_orb, m_ddra, m_ddrb} = '0;
        {m_prev, m_ca2, m_cb2} = '0;
        m_t1_latch = latch;
        {m_t1_snap, m_t1_cnt, m_t1_run} = '0;
        {m_t2_latch, m_t2_snap, m_t2_cnt, m_t2_run} = '0;
        {m_sr, m_pcr, m_acr, m_ier, m_ifr} = '0;
    endfunction

    function automatic void count_timers();
        if (m_t1_run) begin
            if (m_t1_cnt != 0) m_t1_cnt = m_t1_cnt - 17'd1;
            if (m_t1_cnt == 0) begin
                if (m_acr[6]) begin
                    if (m_acr[7]) m_orb[7] = ~m_orb[7];
                    t1_reload();
                end else begin
                    if (m_acr[7]) m_orb[7] = 1'b1;
                    m_t1_run = 1'b0;
                end
                flag_set(via_pkg::F_T1);
            end
        end
        if (m_t2_run) begin
            if (m_t2_cnt != 0) m_t2_cnt = m_t2_cnt - 17'd1;
            if (m_t2_cnt == 0) begin
                m_t2_run = 1'b0;
                flag_set(via_pkg::F_T2);
            end
        end
    endfunction

    function automatic void control_lines(t_bus_cycle c);
        logic [7:0] pc;
        pc = m_pcr;
        if (c.ca1 != m_prev[0]) begin
            if (c.ca1 == pc[0]) begin
                if (m_acr[0]) m_lat_a = c.pa;
                flag_set(via_pkg::F_CA1);
                if (pc[3:2] == 2'b10) m_ca2 = 1'b1;
            end
            m_prev[0] = c.ca1;
        end
        // output mode ignores the pin and keeps the old level
        if (!pc[3] && c.ca2 != m_prev[1]) begin
            if ((c.ca2 && pc[3:2] == 2'b01) || (!c.ca2 && pc[3:2] == 2'b00))
                flag_set(via_pkg::F_CA2);
            m_prev[1] = c.ca2;
        end
        if (c.cb1 != m_prev[2]) begin
            if (c.cb1 == pc[4]) begin
                if (m_acr[1]) m_lat_b = c.pb;
                flag_set(via_pkg::F_CB1);
                if (pc[7:6] == 2'b10) m_cb2 = 1'b1;
            end
            m_prev[2] = c.cb1;
        end
        if (!pc[7] && c.cb2 != m_prev[3]) begin
            if ((c.cb2 && pc[7:6] == 2'b01) || (!c.cb2 && pc[7:6] == 2'b00))
                flag_set(via_pkg::F_CB2);
            m_prev[3] = c.cb2;
        end
    endfunction

    function automatic logic [7:0] reg_read(t_bus_cycle c);
        logic [16:0] t1v, t2v;
        t1v = m_t1_run ? m_t1_cnt : {1'b0, m_t1_snap};
        t2v = m_t2_run ? m_t2_cnt : {1'b0, m_t2_snap};
        case (c.offs)
            via_pkg::REG_ORB: begin
                if (!m_acr[1]) m_lat_b = c.pb;
                port_b_ack();
                return (m_orb & m_ddrb) | (m_lat_b & ~m_ddrb);
            end
            via_pkg::REG_ORA, via_pkg::REG_ORA_NH: begin
                if (c.offs == via_pkg::REG_ORA) begin
                    if (m_pcr[3:2] == 2'b10) m_ca2 = 1'b0;
                    port_a_ack();
                end
                if (!m_acr[0]) m_lat_a = c.pa;
                return (m_ora & m_ddra) | (m_lat_a & ~m_ddra);
            end
            via_pkg::REG_DDRB: return m_ddrb;
            via_pkg::REG_DDRA: return m_ddra;
            via_pkg::REG_T1CL: begin
                flag_clr(via_pkg::F_T1);
                return t1v[7:0];
            end
            via_pkg::REG_T1CH: return t1v[15:8];
            via_pkg::REG_T1LL: return m_t1_latch[7:0];
            via_pkg::REG_T1LH: return m_t1_latch[15:8];
            via_pkg::REG_T2CL: begin
                flag_clr(via_pkg::F_T2);
                return t2v[7:0];
            end
            via_pkg::REG_T2CH: return t2v[15:8];
            via_pkg::REG_SR:   return m_sr;
            via_pkg::REG_PCR:  return m_pcr;
            via_pkg::REG_ACR:  return m_acr;
            via_pkg::REG_IER:  return {1'b1, m_ier};
            default:           return m_ifr;
        endcase
    endfunction

    function automatic void reg_write(logic [3:0] offs, logic [7:0] d, ref t_pin_state r);
        case (offs)
            via_pkg::REG_ORB: begin
                if (m_acr[7]) m_orb = {m_orb[7], d[6:0]};
                else m_orb = d;
                port_b_ack();
                if (m_pcr[7:6] == 2'b10) m_cb2 = 1'b0;
            end
            via_pkg::REG_ORA: begin
                if (m_pcr[3:2] == 2'b10) m_ca2 = 1'b0;
                port_a_ack();
                m_ora = d;
            end
            via_pkg::REG_ORA_NH: m_ora = d;
            via_pkg::REG_DDRB: m_ddrb = d;
            via_pkg::REG_DDRA: m_ddra = d;
            via_pkg::REG_T1CL, via_pkg::REG_T1LL: m_t1_latch[7:0] = d;
            via_pkg::REG_T1LH: m_t1_latch[15:8] = d;
            via_pkg::REG_T1CH: begin
                m_t1_latch[15:8] = d;
                m_t1_snap = m_t1_latch;
                flag_clr(via_pkg::F_T1);
                if (m_acr[7]) m_orb[7] = 1'b0;
                t1_reload();
            end
            via_pkg::REG_T2CL: m_t2_latch[7:0] = d;
            via_pkg::REG_T2CH: begin
                m_t2_latch[15:8] = d;
                m_t2_snap = m_t2_latch;
                flag_clr(via_pkg::F_T2);
                // pulse-count mode leaves a running count alone
                if (!m_acr[5]) begin
                    m_t2_cnt = {1'b0, m_t2_latch} + via_pkg::EXTRA_CYCLES;
                    m_t2_run = 1'b1;
                end
            end
            via_pkg::REG_SR: begin
                m_sr = d;
                if (m_acr[4:2] == via_pkg::SR_OUT_PHI2) begin
                    r.sov = 1'b1;
                    r.sod = d;
                end
            end
            via_pkg::REG_PCR: begin
                m_pcr = d;
                if (d[3:2] == 2'b11) m_ca2 = d[1];
                if (d[7:6] == 2'b11) m_cb2 = d[5];
            end
            via_pkg::REG_ACR: begin
                m_acr = d;
                if (d[7]) m_orb[7] = !m_t1_run;
                if (d[6]) t1_reload();
            end
            via_pkg::REG_IER: begin
                if (d[7]) m_ier = m_ier | d[6:0];
                else m_ier = m_ier & ~d[6:0];
                irq_update();
            end
            default: flag_clr(d[6:0]);
        endcase
    endfunction

    function automatic t_pin_state predict_cycle(t_bus_cycle c);
        t_pin_state r;
        r = '{default: '0};
        count_timers();
        control_lines(c);
        if (c.cmd == via_pkg::CMD_READ) r.rd = reg_read(c);
        else if (c.cmd == via_pkg::CMD_WRITE) reg_write(c.offs, c.wdata, r);
        r.pa_drv = m_ora & m_ddra;
        r.pa_dir = m_ddra;
        r.pb_drv = m_orb & m_ddrb;
        r.pb_dir = m_ddrb;
        r.ca2o = m_ca2;
        r.cb2o = m_cb2;
        r.irq = m_ifr[7];
        return r;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(negedge i_clk) i_out_stall <= ($urandom_range(99) < recv_stall_pct);

    always @(posedge i_clk) begin
        t_pin_state e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_q.size() == 0) begin
                $error("result with no expectation pending");
                err_cnt++;
            end else begin
                e = pending_q.pop_front();
                if (o_read_data !== e.rd) begin
                    $error("read_data exp %h got %h", e.rd, o_read_data); err_cnt++; end
                if (o_port_a_drive !== e.pa_drv) begin
                    $error("port_a_drive exp %h got %h", e.pa_drv, o_port_a_drive); err_cnt++; end
                if (o_port_a_dir !== e.pa_dir) begin
                    $error("port_a_dir exp %h got %h", e.pa_dir, o_port_a_dir); err_cnt++; end
                if (o_port_b_drive !== e.pb_drv) begin
                    $error("port_b_drive exp %h got %h", e.pb_drv, o_port_b_drive); err_cnt++; end
                if (o_port_b_dir !== e.pb_dir) begin
                    $error("port_b_dir exp %h got %h", e.pb_dir, o_port_b_dir); err_cnt++; end
                if (o_ca2_out !== e.ca2o) begin
                    $error("ca2_out exp %b got %b", e.ca2o, o_ca2_out); err_cnt++; end
                if (o_cb2_out !== e.cb2o) begin
                    $error("cb2_out exp %b got %b", e.cb2o, o_cb2_out); err_cnt++; end
                if (o_irq !== e.irq) begin
                    $error("irq exp %b got %b", e.irq, o_irq); err_cnt++; end
                if (o_shift_out_valid !== e.sov) begin
                    $error("shift_out_valid exp %b got %b", e.sov, o_shift_out_valid);
                    err_cnt++;
                end
                if (o_shift_out_data !== e.sod) begin
                    $error("shift_out_data exp %h got %h", e.sod, o_shift_out_data); err_cnt++; end
            end
        end
    end

    // Abort when neither side moves a transaction for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT) begin
            $display("versatile_interface_adapter_tb: done, errors");
            $finish;
        end else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Called at a falling edge; returns at the falling edge after acceptance
    task automatic send_cycle(t_bus_cycle c, bit has_rd, logic [7:0] rd);
        t_pin_state e;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_command = c.cmd;
        i_reg_offset = c.offs;
        i_write_data = c.wdata;
        i_port_a_pins = c.pa;
        i_port_b_pins = c.pb;
        {i_ca1_pin, i_ca2_pin, i_cb1_pin, i_cb2_pin} = {c.ca1, c.ca2, c.cb1, c.cb2};
        do @(posedge i_clk); while (o_in_stall);
        e = predict_cycle(c);
        if (has_rd) e.rd = rd;
        pending_q.push_back(e);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_in_valid = 1'b0;
        while (pending_q.size() != 0) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic load_latch(logic [15:0] v);
        drain();
        i_cfg_we = 1'b1;
        i_cfg_data = v;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        m_t1_latch = v;
    endtask

    function automatic void add_row(logic [1:0] cmd, logic [3:0] offs, logic [7:0] d,
                                    logic [7:0] pa, logic [7:0] pb, logic [3:0] ctl,
                                    bit has_rd, logic [7:0] rd);
        t_table_row t;
        t.cyc = '{cmd, offs, d, pa, pb, ctl[3], ctl[2], ctl[1], ctl[0]};
        t.has_rd = has_rd;
        t.rd = rd;
        rows.push_back(t);
    endfunction

    function automatic t_bus_cycle rand_cycle();
        t_bus_cycle c;
        int k;
        k = $urandom_range(99);
        c.cmd = (k < 25) ? CMD_IDLE : (k < 60) ? via_pkg::CMD_READ :
                (k < 95) ? via_pkg::CMD_WRITE : CMD_ALT;
        c.offs = 4'($urandom_range(15));
        c.wdata = 8'($urandom_range(255));
        // keep timer periods short so expiries happen often
        if (c.cmd == via_pkg::CMD_WRITE && (c.offs == via_pkg::REG_T1CH ||
            c.offs == via_pkg::REG_T1LH || c.offs == via_pkg::REG_T2CH) &&
            $urandom_range(3) != 0)
            c.wdata = 8'h00;
        if (c.cmd == via_pkg::CMD_WRITE && (c.offs == via_pkg::REG_T1CL ||
            c.offs == via_pkg::REG_T1LL || c.offs == via_pkg::REG_T2CL) &&
            $urandom_range(3) != 0)
            c.wdata = 8'($urandom_range(40));
        c.pa = 8'($urandom_range(255));
        c.pb = 8'($urandom_range(255));
        if ($urandom_range(99) < 15) c_ca1 = ~c_ca1;
        if ($urandom_range(99) < 15) c_ca2 = ~c_ca2;
        if ($urandom_range(99) < 15) c_cb1 = ~c_cb1;
        if ($urandom_range(99) < 15) c_cb2 = ~c_cb2;
        {c.ca1, c.ca2, c.cb1, c.cb2} = {c_ca1, c_ca2, c_cb1, c_cb2};
        return c;
    endfunction

    task automatic random_run(int n);
        for (int i = 0; i < n; i++) begin
            if (i == n / 2) drain();
            send_cycle(rand_cycle(), 1'b0, 8'h00);
        end
    endtask

    initial begin
        err_cnt = 0;
        quiet_cycles = 0;
        send_idle_pct = 8;
        recv_stall_pct = 48;
        {c_ca1, c_ca2, c_cb1, c_cb2} = '0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_out_stall = 1'b0;
        i_command = CMD_IDLE;
        i_reg_offset = via_pkg::REG_ORB;
        {i_write_data, i_port_a_pins, i_port_b_pins} = '0;
        {i_ca1_pin, i_ca2_pin, i_cb1_pin, i_cb2_pin} = '0;
        model_reset(via_pkg::T1_LATCH_RESET);
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        add_row(via_pkg::CMD_READ,  via_pkg::REG_IER,  8'h00, 8'h00, 8'h00, 4'b0000, 1, 8'h80);
        add_row(via_pkg::CMD_READ,  via_pkg::REG_T1LL, 8'h00, 8'h00, 8'h00, 4'b0000, 1, 8'hf3);
        add_row(via_pkg::CMD_READ,  via_pkg::REG_T1LH, 8'h00, 8'h00, 8'h00, 4'b0000, 1, 8'hb5);
        add_row(via_pkg::CMD_READ,  via_pkg::REG_IFR,  8'h00, 8'h00, 8'h00, 4'b0000, 1, 8'h00);
        add_row(via_pkg::CMD_WRITE, via_pkg::REG_DDRA, 8'hff, 8'h00, 8'h00, 4'b0000, 0, 8'h00);
        add_row(via_pkg::CMD_READ,  via_pkg::REG_DDRA, 8'h00, 8'hff, 8'hff, 4'b0000, 1, 8'hff);
        add_row(via_pkg::CMD_WRITE, via_pkg::REG_ORA,  8'ha5, 8'h00, 8'h00, 4'b0000, 0, 8'h00);
        add_row(via_pkg::CMD_WRITE, via_pkg::REG_DDRB, 8'h0f, 8'h00, 8'h00, 4'b0000, 0, 8'h00);
        add_row(via_pkg::CMD_WRITE, via_pkg::REG_IER,  8'hff, 8'h00, 8'h00, 4'b0000, 0, 8'h00);
        add_row(via_pkg::CMD_WRITE, via_pkg::REG_ACR,  8'hc3, 8'h00, 8'h00, 4'b1111, 0, 8'h00);
        add_row(via_pkg::CMD_WRITE, via_pkg::REG_T1CL, 8'h02, 8'h00, 8'hff, 4'b0000, 0, 8'h00);
        add_row(via_pkg::CMD_WRITE, via_pkg::REG_T1CH, 8'h00, 8'h5a, 8'ha5, 4'b1010, 0, 8'h00);
        add_row(via_pkg::CMD_READ,  via_pkg::REG_T1CL, 8'h00, 8'h00, 8'h00, 4'b0101, 0, 8'h00);
        add_row(via_pkg::CMD_READ,  via_pkg::REG_T1CH, 8'h00, 8'h00, 8'h00, 4'b0000, 0, 8'h00);
        add_row(via_pkg::CMD_READ,  via_pkg::REG_IFR,  8'h00, 8'h00, 8'h00, 4'b1111, 0, 8'h00);
        add_row(via_pkg::CMD_WRITE, via_pkg::REG_PCR,  8'hee, 8'h00, 8'h00, 4'b0000, 0, 8'h00);
        add_row(via_pkg::CMD_WRITE, via_pkg::REG_PCR,  8'h89, 8'h00, 8'h00, 4'b1010, 0, 8'h00);
        add_row(via_pkg::CMD_READ,  via_pkg::REG_ORA,  8'h00, 8'h3c, 8'h00, 4'b0000, 0, 8'h00);
        add_row(via_pkg::CMD_READ,  via_pkg::REG_ORB,  8'h00, 8'h00, 8'hc3, 4'b1111, 0, 8'h00);
        add_row(via_pkg::CMD_WRITE, via_pkg::REG_ACR,  8'h38, 8'h00, 8'h00, 4'b0000, 0, 8'h00);
        add_row(via_pkg::CMD_WRITE, via_pkg::REG_SR,   8'h5a, 8'h00, 8'h00, 4'b0000, 0, 8'h00);
        add_row(via_pkg::CMD_READ,  via_pkg::REG_SR,   8'h00, 8'h00, 8'h00, 4'b0000, 1, 8'h5a);
        add_row(via_pkg::CMD_WRITE, via_pkg::REG_T2CH, 8'hff, 8'h00, 8'h00, 4'b0000, 0, 8'h00);
        add_row(via_pkg::CMD_WRITE, via_pkg::REG_IFR,  8'h7f, 8'h00, 8'h00, 4'b0000, 0, 8'h00);
        add_row(via_pkg::CMD_READ,  via_pkg::REG_ORA_NH, 8'h00, 8'hff, 8'hff, 4'b0000, 0,
                8'h00);
        add_row(CMD_ALT,            via_pkg::REG_T2CL, 8'hff, 8'hff, 8'hff, 4'b0000, 0, 8'h00);
        foreach (rows[i]) send_cycle(rows[i].cyc, rows[i].has_rd, rows[i].rd);

        load_latch(16'h0000);
        random_run(470);
        send_idle_pct = 48;
        recv_stall_pct = 8;
        load_latch(16'hffff);
        random_run(470);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        load_latch(16'($urandom_range(60)));
        random_run(470);

        i_in_valid = 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
        if (err_cnt == 0)
            $display("versatile_interface_adapter_tb: done, clean");
        else
            $display("versatile_interface_adapter_tb: done, errors");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/via_pkg.sv
hw/rtl/via_timer.sv
hw/rtl/versatile_interface_adapter.sv
verif/versatile_interface_adapter_tb.sv
